[rtl/bffa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, codes and control types of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    // Map geometry
    localparam int MAP_BITS  = 8192;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int MAP_WORDS = MAP_BITS / WORD_W;
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int POS_W     = $clog2(MAP_BITS);
    localparam int MEM_DEPTH = 2 * MAP_WORDS;
    localparam int MEM_AW    = WADDR_W + 1;

    // Field widths
    localparam int NUM_W = 14;
    localparam int REQ_W = 2;
    localparam int ST_W  = 2;

    localparam logic [NUM_W-1:0] CFG_RESET = NUM_W'(8192);

    // Register indexes
    localparam int REG_INODE_COUNT = 0;
    localparam int REG_BLOCK_COUNT = 1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC_INODE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC_BLOCK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE_INODE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FREE_BLOCK  = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_FREE  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch the accepted item
        logic clr;         // write one zero row of the clearing pass
        logic set_range;   // result: number out of range
        logic set_full;    // result: map full without scanning
        logic rd_free;     // read the word holding the number to free
        logic scan_init;   // rewind the scan address
        logic scan;        // issue next scan read, check returned word
        logic chk_free;    // check and clear the bit to free
        logic out_load;    // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_free;
        logic range_bad;
        logic count_zero;
        logic scan_done;
        logic clr_last;
    } t_dp_stat;

endpackage

[rtl/bffa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer of the allocator: clearing pass, request decode, scan, free and
// handoff to the output register.
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  bffa_pkg::t_dp_stat  i_stat,
    output bffa_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_FCHK   = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.is_free) begin
                    if (i_stat.range_bad) begin
                        o_cmd.set_range = 1'b1;
                        n_state         = S_RESULT;
                    end else begin
                        o_cmd.rd_free = 1'b1;
                        n_state       = S_FCHK;
                    end
                end else begin
                    if (i_stat.count_zero) begin
                        o_cmd.set_full = 1'b1;
                        n_state        = S_RESULT;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_FCHK: begin
                o_cmd.chk_free = 1'b1;
                n_state        = S_RESULT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/bffa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_dp
// Datapath of the allocator: bitmap memory (inode map in the lower half,
// block map in the upper half), find-first-zero, used counters and results.
// ----------------------------------------------------------------------------
module bffa_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bffa_pkg::t_dp_cmd               i_cmd,
    output bffa_pkg::t_dp_stat              o_stat,
    input  logic [bffa_pkg::NUM_W-1:0]      i_inode_count,
    input  logic [bffa_pkg::NUM_W-1:0]      i_block_count,
    input  logic [bffa_pkg::REQ_W-1:0]      i_req_type,
    input  logic [bffa_pkg::NUM_W-1:0]      i_item_number,
    output logic [bffa_pkg::NUM_W-1:0]      o_allocated_number,
    output logic [bffa_pkg::ST_W-1:0]       o_status,
    output logic [bffa_pkg::NUM_W-1:0]      o_free_remaining
);

    // Bitmap storage
    logic [bffa_pkg::WORD_W-1:0] r_mem [bffa_pkg::MEM_DEPTH];

    // Latched request
    logic                        r_is_block;
    logic                        r_is_free;
    logic [bffa_pkg::NUM_W-1:0]  r_num;

    // Counters and scan state
    logic [bffa_pkg::NUM_W-1:0]   r_ino_used, r_blk_used;
    logic [bffa_pkg::MEM_AW-1:0]  r_clr_addr;
    logic [bffa_pkg::WADDR_W:0]   r_scan_addr;
    logic                         r_rd_pend;
    logic [bffa_pkg::WADDR_W-1:0] r_rd_word;
    logic [bffa_pkg::WORD_W-1:0]  r_rdata;

    // Results
    logic [bffa_pkg::NUM_W-1:0]  r_res_num;
    logic [bffa_pkg::ST_W-1:0]   r_res_status;
    logic [bffa_pkg::NUM_W-1:0]  r_o_num;
    logic [bffa_pkg::ST_W-1:0]   r_o_status;
    logic [bffa_pkg::NUM_W-1:0]  r_o_free;

    logic [bffa_pkg::NUM_W-1:0]   cfg_count, count_eff, used_sel, count_m1, pos;
    logic [bffa_pkg::WADDR_W-1:0] last_word, pos_word;
    logic [bffa_pkg::BIT_W-1:0]   last_bit, pos_bit, hit_bit;
    logic [bffa_pkg::WORD_W-1:0]  valid_mask, free_bits, pos_mask, hit_mask;
    logic                         hit, issue, rd_en, wr_en, free_ok;
    logic [bffa_pkg::MEM_AW-1:0]  rd_addr, wr_addr;
    logic [bffa_pkg::WORD_W-1:0]  wr_data;

    // Effective count of the addressed map, limited to the map size
    always_comb begin
        cfg_count = r_is_block ? i_block_count : i_inode_count;
        if (32'(cfg_count) > bffa_pkg::MAP_BITS) begin
            count_eff = bffa_pkg::NUM_W'(bffa_pkg::MAP_BITS);
        end else begin
            count_eff = cfg_count;
        end
    end

    assign used_sel  = r_is_block ? r_blk_used : r_ino_used;
    assign count_m1  = count_eff - 1'b1;
    assign last_word = count_m1[bffa_pkg::POS_W-1:bffa_pkg::BIT_W];
    assign last_bit  = count_m1[bffa_pkg::BIT_W-1:0];
    assign pos       = r_num - 1'b1;
    assign pos_word  = pos[bffa_pkg::POS_W-1:bffa_pkg::BIT_W];
    assign pos_bit   = pos[bffa_pkg::BIT_W-1:0];
    assign pos_mask  = bffa_pkg::WORD_W'(1) << pos_bit;

    // Bits beyond the count in the last word count as taken
    always_comb begin
        if (r_rd_word == last_word) begin
            valid_mask = {bffa_pkg::WORD_W{1'b1}}
                         >> (bffa_pkg::BIT_W'(bffa_pkg::WORD_W - 1) - last_bit);
        end else begin
            valid_mask = {bffa_pkg::WORD_W{1'b1}};
        end
    end

    assign free_bits = ~r_rdata & valid_mask;
    assign hit       = r_rd_pend && (free_bits != '0);

    // Find first zero: lowest free bit of the returned word
    always_comb begin
        hit_bit = '0;
        for (int b = bffa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit_bit = bffa_pkg::BIT_W'(b);
            end
        end
    end
    assign hit_mask = bffa_pkg::WORD_W'(1) << hit_bit;

    assign free_ok = (r_rdata & pos_mask) != '0;

    // Status to the controller
    assign o_stat.is_free    = r_is_free;
    assign o_stat.range_bad  = (r_num == '0) || (r_num > count_eff);
    assign o_stat.count_zero = (count_eff == '0);
    assign o_stat.scan_done  = r_rd_pend && (hit || (r_rd_word == last_word));
    assign o_stat.clr_last   = (r_clr_addr == bffa_pkg::MEM_AW'(bffa_pkg::MEM_DEPTH - 1));

    // Memory read port
    assign issue   = i_cmd.scan && (r_scan_addr <= {1'b0, last_word}) && !hit;
    assign rd_en   = i_cmd.rd_free || issue;
    assign rd_addr = i_cmd.rd_free ? {r_is_block, pos_word}
                                   : {r_is_block, r_scan_addr[bffa_pkg::WADDR_W-1:0]};

    // Memory write port: clearing pass, grant, or release
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        if (i_cmd.clr) begin
            wr_en = 1'b1;
        end else if (i_cmd.scan && hit) begin
            wr_en   = 1'b1;
            wr_addr = {r_is_block, r_rd_word};
            wr_data = r_rdata | hit_mask;
        end else if (i_cmd.chk_free && free_ok) begin
            wr_en   = 1'b1;
            wr_addr = {r_is_block, pos_word};
            wr_data = r_rdata & ~pos_mask;
        end
    end

    // Bitmap memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Control registers: clearing address, scan address, read tracking, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_scan_addr <= '0;
            r_rd_pend   <= 1'b0;
            r_ino_used  <= '0;
            r_blk_used  <= '0;
        end else begin
            r_rd_pend <= rd_en && !i_cmd.rd_free;
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_scan_addr <= '0;
            end else if (issue) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            // Count grants up and releases down
            if (i_cmd.scan && hit) begin
                if (r_is_block) begin
                    r_blk_used <= r_blk_used + 1'b1;
                end else begin
                    r_ino_used <= r_ino_used + 1'b1;
                end
            end else if (i_cmd.chk_free && free_ok) begin
                if (r_is_block) begin
                    r_blk_used <= r_blk_used - 1'b1;
                end else begin
                    r_ino_used <= r_ino_used - 1'b1;
                end
            end
        end
    end

    // Payload registers: request, word tag, results
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_word <= r_scan_addr[bffa_pkg::WADDR_W-1:0];
        end
        if (i_cmd.load) begin
            r_is_block <= (i_req_type == bffa_pkg::REQ_ALLOC_BLOCK)
                       || (i_req_type == bffa_pkg::REQ_FREE_BLOCK);
            r_is_free  <= (i_req_type == bffa_pkg::REQ_FREE_INODE)
                       || (i_req_type == bffa_pkg::REQ_FREE_BLOCK);
            r_num      <= i_item_number;
        end
        if (i_cmd.set_range) begin
            r_res_num    <= '0;
            r_res_status <= bffa_pkg::ST_RANGE;
        end
        if (i_cmd.set_full) begin
            r_res_num    <= '0;
            r_res_status <= bffa_pkg::ST_FULL;
        end
        if (i_cmd.chk_free) begin
            r_res_num    <= '0;
            r_res_status <= free_ok ? bffa_pkg::ST_OK : bffa_pkg::ST_FREE;
        end
        if (i_cmd.scan && r_rd_pend) begin
            if (hit) begin
                r_res_num    <= bffa_pkg::NUM_W'({r_rd_word, hit_bit}) + 1'b1;
                r_res_status <= bffa_pkg::ST_OK;
            end else begin
                r_res_num    <= '0;
                r_res_status <= bffa_pkg::ST_FULL;
            end
        end
        if (i_cmd.out_load) begin
            r_o_num    <= r_res_num;
            r_o_status <= r_res_status;
            r_o_free   <= (count_eff > used_sel) ? (count_eff - used_sel) : '0;
        end
    end

    assign o_allocated_number = r_o_num;
    assign o_status           = r_o_status;
    assign o_free_remaining   = r_o_free;

endmodule

[rtl/bitmap_first_fit_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// First-fit allocator over an inode bitmap and a block bitmap, with an APB
// register port for the managed counts.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | tuser req_type, tdata number
//  m_axis   | out       | m_axis_tvalid/tready      | tuser status, tdata number+free
//  apb      | in        | psel/penable/pwrite/pready| inode_count @0, block_count @4
//
//  A free passes the decide and check states (only decide when out of range or
//  the count is zero); an allocate scans one 32-bit word a cycle through the
//  registered memory read port until a free bit or the last word of the count is
//  found. The next item is taken the cycle after a result is loaded. After reset
//  a clearing pass writes 512 memory rows, one a cycle, with s_axis_tready low.
//  A waiting result holds back the next one, and s_axis_tready stays low.
//
module bitmap_first_fit_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [13:0] item_number, [15:14] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [13:0] allocated_number, [27:14] free_remaining
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [bffa_pkg::NUM_W-1:0] r_inode_count, r_block_count;
    logic [bffa_pkg::NUM_W-1:0] alloc_num, free_rem;
    logic [bffa_pkg::ST_W-1:0]  status;
    logic                       cfg_wr;
    bffa_pkg::t_dp_cmd          cmd;
    bffa_pkg::t_dp_stat         stat;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inode_count <= bffa_pkg::CFG_RESET;
            r_block_count <= bffa_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == 1'(bffa_pkg::REG_INODE_COUNT)) begin
                r_inode_count <= pwdata[bffa_pkg::NUM_W-1:0];
            end else begin
                r_block_count <= pwdata[bffa_pkg::NUM_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            1'(bffa_pkg::REG_INODE_COUNT): prdata = 32'(r_inode_count);
            1'(bffa_pkg::REG_BLOCK_COUNT): prdata = 32'(r_block_count);
            default:                       prdata = '0;
        endcase
    end

    bffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bffa_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_inode_count      (r_inode_count),
        .i_block_count      (r_block_count),
        .i_req_type         (s_axis_tuser),
        .i_item_number      (s_axis_tdata[bffa_pkg::NUM_W-1:0]),
        .o_allocated_number (alloc_num),
        .o_status           (status),
        .o_free_remaining   (free_rem)
    );

    // Pack the result item
    assign m_axis_tdata = {4'b0000, free_rem, alloc_num};
    assign m_axis_tuser = status;

endmodule

[rtl/bffa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks of the bitmap first-fit allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bffa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Grant a number only with status ok
    a_num_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != bffa_pkg::ST_OK) |-> m_axis_tdata[13:0] == 14'd0)
        else $error("number granted with a failing status");

    // Free space never exceeds the map size
    a_free_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[27:14]) <= bffa_pkg::MAP_BITS)
        else $error("free space above map size");

    // Take no item when reset is released, as the clearing pass is running
    a_clear_block: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !s_axis_tready)
        else $error("item taken during clearing pass");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
